[rtl/yprgb_pkg.sv]
// Shared types and constants for the YUYV pair to RGB shift-add converter.
package yprgb_pkg;

    localparam int BYTE_W   = 8;
    localparam int CHROMA_W = BYTE_W + 1;
    localparam int SUM_W    = BYTE_W + 3;

    localparam logic [CHROMA_W-1:0] CHROMA_OFFSET = CHROMA_W'(128);
    localparam logic [BYTE_W-1:0]   BYTE_MAX      = BYTE_W'(255);

    typedef struct packed {
        logic [BYTE_W-1:0] chan_two;
        logic [BYTE_W-1:0] chan_one;
        logic [BYTE_W-1:0] chan_zero;
    } t_rgb;

endpackage

[rtl/yuyv_pair_to_rgb_shift_add_top.sv]
// Top level: two-register stream pipeline converting YUYV pairs to two RGB pixels.
//
// Converts one packed 4:2:2 group (Y0, U, Y1, V) per item into two pixels of
// three clamped 8-bit channels each, using shift-add approximations of the
// color matrix. Throughput is one item per clock while the output accepts.
// An item sits in the input register after the edge that accepts it and moves
// to the result register when that register is empty or being read, so output
// valid comes from a register. The two registers form a pipeline that keeps
// accepting while a finished result waits, so input tready drops only when
// both stages hold items. tlast is carried through unchanged. No
// configuration; only the valid flags are reset.
module yuyv_pair_to_rgb_shift_add_top
    import yprgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_byte_one, [23:16] luma_second,
    // [31:24] chroma_byte_three
    input  logic [31:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] first_chan_zero, [15:8] first_chan_one, [23:16] first_chan_two,
    // [31:24] second_chan_zero, [39:32] second_chan_one, [47:40] second_chan_two
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [31:0] r_s1_data;
    logic        r_s1_last;
    logic        r_m_valid;
    logic        n_m_valid;
    t_rgb        r_m_first;
    t_rgb        r_m_second;
    logic        r_m_last;

    logic        in_accept;
    logic        m_free;
    logic        s1_move;
    t_rgb        pix_first;
    t_rgb        pix_second;

    assign m_free          = !r_m_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && m_free;
    assign o_s_axis_tready = !r_s1_valid || m_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_m_valid = r_m_valid;
        if (s1_move) begin
            n_m_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_s_axis_tdata;
            r_s1_last <= i_s_axis_tlast;
        end
        if (s1_move) begin
            r_m_first  <= pix_first;
            r_m_second <= pix_second;
            r_m_last   <= r_s1_last;
        end
    end

    yprgb_pixel u_pix_first (
        .i_luma         (r_s1_data[7:0]),
        .i_chroma_one   (r_s1_data[15:8]),
        .i_chroma_three (r_s1_data[31:24]),
        .o_pix          (pix_first)
    );

    yprgb_pixel u_pix_second (
        .i_luma         (r_s1_data[23:16]),
        .i_chroma_one   (r_s1_data[15:8]),
        .i_chroma_three (r_s1_data[31:24]),
        .o_pix          (pix_second)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_second.chan_two, r_m_second.chan_one, r_m_second.chan_zero,
                              r_m_first.chan_two, r_m_first.chan_one, r_m_first.chan_zero};
    assign o_m_axis_tlast  = r_m_last;

    // stall input only when both stages are occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_m_valid))
        else $error("input stalled with a free stage");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted item not held in input stage");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> (r_m_valid && (o_m_axis_tlast == $past(r_s1_last))))
        else $error("result register not loaded from input stage");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move && !in_accept) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("waiting item lost from input stage");

endmodule

[rtl/yprgb_pixel.sv]
// One pixel of the conversion: chroma offset, shift-add channel sums and clamp.
module yprgb_pixel
    import yprgb_pkg::*;
(
    input  logic [BYTE_W-1:0] i_luma,
    input  logic [BYTE_W-1:0] i_chroma_one,
    input  logic [BYTE_W-1:0] i_chroma_three,
    output t_rgb              o_pix
);

    logic signed [CHROMA_W-1:0] p;
    logic signed [CHROMA_W-1:0] q;
    logic signed [SUM_W-1:0]    p_w;
    logic signed [SUM_W-1:0]    q_w;
    logic signed [SUM_W-1:0]    y_w;
    logic signed [SUM_W-1:0]    sum0;
    logic signed [SUM_W-1:0]    sum1;
    logic signed [SUM_W-1:0]    sum2;

    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] c);
        logic [BYTE_W-1:0] r;
        if (c[SUM_W-1]) begin
            r = '0;
        end else if (c > $signed({3'b000, BYTE_MAX})) begin
            r = BYTE_MAX;
        end else begin
            r = c[BYTE_W-1:0];
        end
        return r;
    endfunction

    // remove the chroma offset; the result always fits a 9-bit signed value
    assign p = $signed({1'b0, i_chroma_one} - CHROMA_OFFSET);
    assign q = $signed({1'b0, i_chroma_three} - CHROMA_OFFSET);

    assign p_w = {{(SUM_W-CHROMA_W){p[CHROMA_W-1]}}, p};
    assign q_w = {{(SUM_W-CHROMA_W){q[CHROMA_W-1]}}, q};
    assign y_w = $signed({3'b000, i_luma});

    // arithmetic shifts round toward minus infinity
    assign sum0 = y_w + q_w + (q_w >>> 1) + (q_w >>> 2) + (q_w >>> 6);
    assign sum1 = y_w - ((q_w >>> 2) + (q_w >>> 4) + (q_w >>> 5))
                      - ((p_w >>> 1) + (p_w >>> 3) + (p_w >>> 4) + (p_w >>> 5));
    assign sum2 = y_w + p_w + (p_w >>> 2) + (p_w >>> 3) + (p_w >>> 5);

    assign o_pix.chan_zero = clamp_byte(sum0);
    assign o_pix.chan_one  = clamp_byte(sum1);
    assign o_pix.chan_two  = clamp_byte(sum2);

endmodule

[verif/yuyv_pair_to_rgb_shift_add_top_tb.sv]
// Self-checking stream testbench for the YUYV pair to RGB shift-add converter.
module yuyv_pair_to_rgb_shift_add_top_tb;
    import yprgb_pkg::*;

    localparam int RANDOM_PAIRS = 1550;
    localparam int CALM_TAIL    = 200;
    localparam int LONG_STALL   = 300;
    localparam int END_SLACK    = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [7:0] luma_a;
        logic [7:0] chroma_u;
        logic [7:0] luma_b;
        logic [7:0] chroma_v;
        logic       last;
        logic       drain_first;
    } t_pair;

    typedef struct {
        t_rgb first;
        t_rgb second;
        logic last;
    } t_pixels;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [7:0] luma_first, [15:8] chroma_byte_one, [23:16] luma_second,
    // [31:24] chroma_byte_three
    logic [31:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [7:0] first_chan_zero, [15:8] first_chan_one, [23:16] first_chan_two,
    // [31:24] second_chan_zero, [39:32] second_chan_one, [47:40] second_chan_two
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_pair   pending_q[$];
    t_pixels rgb_expected_q[$];
    t_pair   cur_pair;

    int total_pairs;
    int pairs_sent   = 0;
    int pairs_seen   = 0;
    int frames_seen  = 0;
    int clamped_low  = 0;
    int clamped_high = 0;
    int error_count  = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int cycle_count  = 0;
    logic rx_hold    = 1'b0;

    yuyv_pair_to_rgb_shift_add_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] clamp_chan(int sum);
        if (sum < 0) begin
            clamped_low++;
            return 8'd0;
        end
        if (sum > 255) begin
            clamped_high++;
            return BYTE_MAX;
        end
        return sum[7:0];
    endfunction

    // Shifts on int are arithmetic, so negative chroma rounds toward minus infinity.
    function automatic t_rgb pixel_from_yuv(logic [7:0] luma, int p, int q);
        t_rgb px;
        int   y;
        y = int'(luma);
        px.chan_zero = clamp_chan(y + q + (q >>> 1) + (q >>> 2) + (q >>> 6));
        px.chan_one  = clamp_chan(y - ((q >>> 2) + (q >>> 4) + (q >>> 5))
                                    - ((p >>> 1) + (p >>> 3) + (p >>> 4) + (p >>> 5)));
        px.chan_two  = clamp_chan(y + p + (p >>> 2) + (p >>> 3) + (p >>> 5));
        return px;
    endfunction

    function automatic t_pixels convert_pair(t_pair pr);
        t_pixels px;
        int      p;
        int      q;
        p = int'(pr.chroma_u) - 128;
        q = int'(pr.chroma_v) - 128;
        px.first  = pixel_from_yuv(pr.luma_a, p, q);
        px.second = pixel_from_yuv(pr.luma_b, p, q);
        px.last   = pr.last;
        return px;
    endfunction

    // Idle in bursts, except in quiet stretches and in the closing part of the run.
    function automatic bit idling_on(int n);
        return (n < total_pairs - CALM_TAIL) && ((n / 150) % 4 != 3);
    endfunction

    task automatic add_pair(int ya, int u, int yb, int v, bit last, bit drain);
        t_pair pr;
        pr.luma_a      = ya[7:0];
        pr.chroma_u    = u[7:0];
        pr.luma_b      = yb[7:0];
        pr.chroma_v    = v[7:0];
        pr.last        = last;
        pr.drain_first = drain;
        pending_q.push_back(pr);
    endtask

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver: present the next pending item, predict its pixels once it is accepted.
    always @(posedge i_clk) begin
        t_pair nxt;
        logic  busy;
        busy = i_s_axis_tvalid;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            rgb_expected_q.push_back(convert_pair(cur_pair));
            pairs_sent++;
            busy = 1'b0;
        end
        if (i_rst_n && !busy) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && rgb_expected_q.size() > 0)) begin
                nxt = pending_q.pop_front();
                cur_pair = nxt;
                i_s_axis_tdata  <= {nxt.chroma_v, nxt.luma_b, nxt.chroma_u, nxt.luma_a};
                i_s_axis_tlast  <= nxt.last;
                i_s_axis_tvalid <= 1'b1;
                if (idling_on(pairs_sent) && $urandom_range(5) == 0)
                    send_gap = $urandom_range(9, 1);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_pixels want;
        t_rgb    got_first;
        t_rgb    got_second;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (rgb_expected_q.size() == 0) begin
                $error("unexpected result item: tdata %h tlast %b",
                       o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                want       = rgb_expected_q.pop_front();
                got_first  = t_rgb'(o_m_axis_tdata[23:0]);
                got_second = t_rgb'(o_m_axis_tdata[47:24]);
                check_chan("first_chan_zero",  want.first.chan_zero,  got_first.chan_zero);
                check_chan("first_chan_one",   want.first.chan_one,   got_first.chan_one);
                check_chan("first_chan_two",   want.first.chan_two,   got_first.chan_two);
                check_chan("second_chan_zero", want.second.chan_zero, got_second.chan_zero);
                check_chan("second_chan_one",  want.second.chan_one,  got_second.chan_one);
                check_chan("second_chan_two",  want.second.chan_two,  got_second.chan_two);
                if (o_m_axis_tlast !== want.last) begin
                    $error("frame_done: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    error_count++;
                end
                if (want.last)
                    frames_seen++;
            end
            pairs_seen++;
        end
        if (!i_rst_n || rx_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (idling_on(pairs_seen) && $urandom_range(5) == 0)
                recv_gap = $urandom_range(9, 1);
        end
    end

    // Hold off the receiver for a long stretch so the pipeline fills and stalls its input.
    initial begin
        while (pairs_sent < 400)
            @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_STALL) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int  frame_left;
        int  ya;
        int  yb;
        int  u;
        int  v;
        bit  last;

        // Directed: extremes, neutral chroma, both clamp directions.
        add_pair(0,   128, 0,   128, 1'b0, 1'b0);
        add_pair(255, 128, 255, 128, 1'b1, 1'b0);
        add_pair(0,   0,   0,   0,   1'b0, 1'b0);
        add_pair(255, 255, 255, 255, 1'b0, 1'b0);
        add_pair(0,   255, 255, 0,   1'b1, 1'b0);
        add_pair(255, 0,   0,   255, 1'b0, 1'b0);
        add_pair(128, 0,   128, 255, 1'b0, 1'b0);
        add_pair(128, 255, 128, 0,   1'b1, 1'b0);
        add_pair(16,  128, 235, 128, 1'b0, 1'b0);
        add_pair(0,   127, 255, 129, 1'b0, 1'b0);
        add_pair(255, 1,   0,   254, 1'b1, 1'b0);
        add_pair(0,   129, 0,   127, 1'b0, 1'b0);
        add_pair(1,   192, 254, 64,  1'b0, 1'b0);
        add_pair(200, 64,  50,  192, 1'b1, 1'b0);
        add_pair(85,  170, 170, 85,  1'b0, 1'b0);
        add_pair(170, 85,  85,  170, 1'b1, 1'b0);
        add_pair(127, 1,   128, 255, 1'b0, 1'b0);
        add_pair(64,  255, 192, 255, 1'b1, 1'b0);

        frame_left = $urandom_range(40, 1);
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if ($urandom_range(9) < 7) begin
                ya = $urandom_range(255);
                yb = $urandom_range(255);
                u  = $urandom_range(255);
                v  = $urandom_range(255);
            end else begin
                // Push luma and chroma toward the corners where channels clamp.
                ya = $urandom_range(1) ? $urandom_range(15) : $urandom_range(255, 240);
                yb = $urandom_range(1) ? $urandom_range(15) : $urandom_range(255, 240);
                u  = $urandom_range(1) ? $urandom_range(31) : $urandom_range(255, 224);
                v  = $urandom_range(1) ? $urandom_range(31) : $urandom_range(255, 224);
            end
            frame_left--;
            last = (frame_left == 0);
            if (last)
                frame_left = $urandom_range(40, 1);
            add_pair(ya, u, yb, v, last, i == 800);
        end
        total_pairs = pending_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (rgb_expected_q.size() > 0)
            @(posedge i_clk);
        repeat (END_SLACK) @(posedge i_clk);

        if (rgb_expected_q.size() > 0) begin
            $error("%0d predicted results never arrived", rgb_expected_q.size());
            error_count++;
        end
        $display("Converted %0d pixel pairs across %0d frames, %0d mismatches.",
                 pairs_seen, frames_seen, error_count);
        $display("Channels clamped: %0d at zero, %0d at full scale.",
                 clamped_low, clamped_high);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
